FILE: hdl/lmne_pkg.sv
// Shared types, constants and symbol tables of the list marker numeral encoder.
`default_nettype none

package lmne_pkg;

  localparam logic [3:0] KIND_DISC           = 4'd0;
  localparam logic [3:0] KIND_CIRCLE         = 4'd1;
  localparam logic [3:0] KIND_SQUARE         = 4'd2;
  localparam logic [3:0] KIND_DECIMAL        = 4'd3;
  localparam logic [3:0] KIND_ZERO_PAD       = 4'd4;
  localparam logic [3:0] KIND_LOWER_ROMAN    = 4'd5;
  localparam logic [3:0] KIND_UPPER_ROMAN    = 4'd6;
  localparam logic [3:0] KIND_LOWER_ARMENIAN = 4'd7;
  localparam logic [3:0] KIND_UPPER_ARMENIAN = 4'd8;
  localparam logic [3:0] KIND_GEORGIAN       = 4'd9;
  localparam logic [3:0] KIND_LOWER_GREEK    = 4'd10;
  localparam logic [3:0] KIND_LOWER_LATIN    = 4'd11;
  localparam logic [3:0] KIND_UPPER_LATIN    = 4'd12;
  localparam logic [3:0] KIND_CJK            = 4'd13;
  localparam logic [3:0] KIND_TIBETAN        = 4'd14;

  localparam int NumStages = 8;
  localparam int DdBitsPerStage = 4;

  localparam logic [31:0] RECIP_26 = 32'd2643056798;
  localparam logic [31:0] RECIP_24 = 32'd2863311531;

  typedef enum logic [3:0] {
    MD_NONE, MD_BULLET, MD_DEC, MD_CJK, MD_TIB, MD_ROMAN, MD_GEO, MD_ARM, MD_LET
  } mode_e;

  typedef enum logic [1:0] {PH_SIGN, PH_BODY, PH_SUF} ph_e;

  typedef struct packed {
    mode_e           mode;
    logic [3:0]      kind;
    logic            neg;
    logic            pad;
    logic            suffix;
    logic [39:0]     mag_bcd;
    logic [31:0]     mag_bin;
    logic [39:0]     lim_bcd;
    logic [31:0]     lim_bin;
    logic [30:0]     let_val;
    logic [7:0][4:0] let_dig;
    logic [3:0]      let_n;
  } step_t;

  function automatic logic [71:0] dd_step(logic [71:0] x);
    logic [71:0] y;
    y = x;
    for (int d = 0; d < 10; d++) begin
      if (y[32+4*d +: 4] >= 4'd5) begin
        y[32+4*d +: 4] = y[32+4*d +: 4] + 4'd3;
      end
    end
    return {y[70:0], 1'b0};
  endfunction

  function automatic logic [3:0] digit_count(logic [39:0] bcd);
    logic [3:0] c;
    c = 4'd1;
    for (int i = 1; i < 10; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        c = 4'(i + 1);
      end
    end
    return c;
  endfunction

  function automatic logic [4:0] hi_bit(logic [9:0] m);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        r = {1'b1, 4'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [20:0] roman_sym(logic upper, logic [3:0] idx);
    logic [20:0] c;
    case (idx)
      4'd0: c = 21'h69;
      4'd1: c = 21'h76;
      4'd2: c = 21'h78;
      4'd3: c = 21'h6C;
      4'd4: c = 21'h63;
      4'd5: c = 21'h64;
      4'd6: c = 21'h6D;
      default: c = 21'h20;
    endcase
    return upper ? (c - 21'h20) : c;
  endfunction

  function automatic logic [20:0] geo_sym(logic [1:0] p, logic [3:0] x);
    logic [20:0] c;
    c = 21'h0;
    case (p)
      2'd3: begin
        case (x)
          4'd1: c = 21'h10E9; 4'd2: c = 21'h10EA; 4'd3: c = 21'h10EB;
          4'd4: c = 21'h10EC; 4'd5: c = 21'h10ED; 4'd6: c = 21'h10EE;
          4'd7: c = 21'h10F4; 4'd8: c = 21'h10EF; 4'd9: c = 21'h10F0;
          default: c = 21'h0;
        endcase
      end
      2'd2: begin
        case (x)
          4'd1: c = 21'h10E0; 4'd2: c = 21'h10E1; 4'd3: c = 21'h10E2;
          4'd4: c = 21'h10F3; 4'd5: c = 21'h10E4; 4'd6: c = 21'h10E5;
          4'd7: c = 21'h10E6; 4'd8: c = 21'h10E7; 4'd9: c = 21'h10E8;
          default: c = 21'h0;
        endcase
      end
      2'd1: begin
        case (x)
          4'd1: c = 21'h10D8; 4'd2: c = 21'h10D9; 4'd3: c = 21'h10DA;
          4'd4: c = 21'h10DB; 4'd5: c = 21'h10DC; 4'd6: c = 21'h10F2;
          4'd7: c = 21'h10DD; 4'd8: c = 21'h10DE; 4'd9: c = 21'h10DF;
          default: c = 21'h0;
        endcase
      end
      default: begin
        case (x)
          4'd1: c = 21'h10D0; 4'd2: c = 21'h10D1; 4'd3: c = 21'h10D2;
          4'd4: c = 21'h10D3; 4'd5: c = 21'h10D4; 4'd6: c = 21'h10D5;
          4'd7: c = 21'h10D6; 4'd8: c = 21'h10F1; 4'd9: c = 21'h10D7;
          default: c = 21'h0;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [20:0] cjk_sym(logic [3:0] x);
    logic [20:0] c;
    case (x)
      4'd0: c = 21'h3007; 4'd1: c = 21'h4E00; 4'd2: c = 21'h4E8C;
      4'd3: c = 21'h4E09; 4'd4: c = 21'h56DB; 4'd5: c = 21'h4E94;
      4'd6: c = 21'h516D; 4'd7: c = 21'h4E03; 4'd8: c = 21'h516B;
      4'd9: c = 21'h4E5D;
      default: c = 21'h0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/list_marker_numeral_encoder_top.sv
// Top level of the list marker numeral encoder.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser: kind[3:0]; tdata: item_number, pad_limit, add_suffix
//  m_axis    out        tdata: code_point[20:0]; tlast: last
//
// An item passes an input register and eight conversion stages (binary to BCD,
// four bits a stage, and one bijective letter digit a stage), then the sequencer
// sends one code point a cycle while the output is ready; the conversion pipeline
// takes a new item every cycle unless a busy sequencer holds its last stage.
// Reset clears all valid bits. A stall at the output holds the whole pipeline.
`default_nettype none

module list_marker_numeral_encoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // item_number[31:0], pad_limit[62:32], add_suffix[63]
  input  wire logic [3:0]  s_axis_tuser,   // kind[3:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // code_point[20:0], zero fill
  output logic             m_axis_tlast    // last
);

  logic                    en;
  logic                    take;
  logic                    s0_valid_q;
  lmne_pkg::step_t         s0_q, s0_d;
  logic [lmne_pkg::NumStages:0] v;
  lmne_pkg::step_t [lmne_pkg::NumStages:0] d;

  always_comb begin
    logic signed [31:0] num;
    logic signed [31:0] lim;
    logic [31:0]        raw;
    raw = s_axis_tdata[31:0];
    num = signed'(raw);
    lim = signed'({1'b0, s_axis_tdata[62:32]});
    s0_d         = '0;
    s0_d.kind    = s_axis_tuser;
    s0_d.neg     = raw[31];
    s0_d.suffix  = s_axis_tdata[63];
    s0_d.mag_bin = raw[31] ? (~raw + 32'd1) : raw;
    s0_d.lim_bin = {1'b0, s_axis_tdata[62:32]};
    s0_d.mode    = lmne_pkg::MD_DEC;
    case (s_axis_tuser)
      lmne_pkg::KIND_DISC, lmne_pkg::KIND_CIRCLE, lmne_pkg::KIND_SQUARE:
        s0_d.mode = lmne_pkg::MD_BULLET;
      lmne_pkg::KIND_DECIMAL: s0_d.mode = lmne_pkg::MD_DEC;
      lmne_pkg::KIND_ZERO_PAD: s0_d.pad = (num >= 32'sd1) && (num <= lim);
      lmne_pkg::KIND_LOWER_ROMAN, lmne_pkg::KIND_UPPER_ROMAN:
        if (num >= 32'sd1 && num <= 32'sd3999) s0_d.mode = lmne_pkg::MD_ROMAN;
      lmne_pkg::KIND_LOWER_ARMENIAN, lmne_pkg::KIND_UPPER_ARMENIAN:
        if (num >= 32'sd0 && num <= 32'sd99999999) s0_d.mode = lmne_pkg::MD_ARM;
      lmne_pkg::KIND_GEORGIAN:
        if (num >= 32'sd1 && num <= 32'sd19999) s0_d.mode = lmne_pkg::MD_GEO;
      lmne_pkg::KIND_LOWER_GREEK, lmne_pkg::KIND_LOWER_LATIN, lmne_pkg::KIND_UPPER_LATIN:
        if (num >= 32'sd1) s0_d.mode = lmne_pkg::MD_LET;
      lmne_pkg::KIND_CJK:
        if (num >= 32'sd0) s0_d.mode = lmne_pkg::MD_CJK;
      lmne_pkg::KIND_TIBETAN:
        if (num >= 32'sd0) s0_d.mode = lmne_pkg::MD_TIB;
      default: s0_d.mode = lmne_pkg::MD_NONE;
    endcase
    if (s0_d.mode == lmne_pkg::MD_LET) begin
      s0_d.let_val = raw[30:0];
    end
  end

  assign en            = !v[lmne_pkg::NumStages] || take;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
    end
  end

  assign v[0] = s0_valid_q;
  assign d[0] = s0_q;

  for (genvar g = 0; g < lmne_pkg::NumStages; g++) begin : g_stage
    lmne_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[g]),
      .data_i  (d[g]),
      .valid_o (v[g+1]),
      .data_o  (d[g+1])
    );
  end

  lmne_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v[lmne_pkg::NumStages]),
    .data_i        (d[lmne_pkg::NumStages]),
    .take_o        (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: hdl/lmne_step.sv
// One conversion stage: four binary-to-BCD steps on two values and one bijective letter digit.
`default_nettype none

module lmne_step (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire lmne_pkg::step_t data_i,
  output logic                valid_o,
  output lmne_pkg::step_t     data_o
);

  logic            valid_q;
  lmne_pkg::step_t data_q, data_d;

  always_comb begin
    logic [71:0] mag_x;
    logic [71:0] lim_x;
    logic [30:0] t;
    logic [31:0] m;
    logic [62:0] prod;
    logic [26:0] q;
    logic [30:0] qb;
    logic [30:0] rem;
    logic        greek;
    data_d = data_i;
    mag_x  = {data_i.mag_bcd, data_i.mag_bin};
    lim_x  = {data_i.lim_bcd, data_i.lim_bin};
    for (int k = 0; k < lmne_pkg::DdBitsPerStage; k++) begin
      mag_x = lmne_pkg::dd_step(mag_x);
      lim_x = lmne_pkg::dd_step(lim_x);
    end
    data_d.mag_bcd = mag_x[71:32];
    data_d.mag_bin = mag_x[31:0];
    data_d.lim_bcd = lim_x[71:32];
    data_d.lim_bin = lim_x[31:0];
    greek = (data_i.kind == lmne_pkg::KIND_LOWER_GREEK);
    t     = data_i.let_val - 31'd1;
    m     = greek ? lmne_pkg::RECIP_24 : lmne_pkg::RECIP_26;
    prod  = 63'(t) * 63'(m);
    q     = prod[62:36];
    qb    = {q, 4'b0} + {1'b0, q, 3'b0} + (greek ? 31'd0 : {3'b0, q, 1'b0});
    rem   = t - qb;
    if (data_i.let_val != 31'd0) begin
      data_d.let_val = {4'b0, q};
      data_d.let_dig[data_i.let_n[2:0]] = rem[4:0];
      data_d.let_n = data_i.let_n + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: hdl/lmne_emit.sv
// Marker sequencer: lays out the symbols of one converted number and sends them one code point per output beat.
`default_nettype none

module lmne_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire lmne_pkg::step_t data_i,
  output logic                 take_o,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // code_point[20:0], zero fill
  output logic                 m_axis_tlast    // last
);

  logic                busy_q, busy_d;
  lmne_pkg::ph_e       ph_q, ph_d;
  logic [3:0]          pos_q, pos_d;
  logic [1:0]          sub_q, sub_d;
  logic                sp_q, sp_d;
  lmne_pkg::mode_e     mode_q;
  logic [3:0]          kind_q;
  logic [9:0]          mask_q;
  logic [9:0][1:0]     lenm1_q;
  logic [1:0]          suflen_q;
  logic [9:0][3:0]     dig_q;
  logic [7:0][4:0]     let_q;
  logic                out_valid_q;
  logic [20:0]         cp_q;
  logic                last_q;

  lmne_pkg::mode_e     p_mode;
  logic [9:0]          p_mask;
  logic [9:0][1:0]     p_lenm1;
  logic [1:0]          p_suflen;
  logic                p_sign;
  logic [4:0]          p_top;

  logic                load;
  logic                adv;
  logic [20:0]         cp;
  logic                last;
  logic                end_pos;
  logic [4:0]          nxt;

  always_comb begin
    logic [3:0] ndig;
    logic [3:0] lw;
    logic [3:0] w;
    logic [3:0] x;
    ndig     = lmne_pkg::digit_count(data_i.mag_bcd);
    lw       = lmne_pkg::digit_count(data_i.lim_bcd);
    w        = (data_i.pad && lw > ndig) ? lw : ndig;
    p_mode   = data_i.mode;
    p_sign   = (data_i.mode == lmne_pkg::MD_DEC) && data_i.neg;
    p_mask   = 10'd0;
    p_lenm1  = '0;
    case (data_i.mode)
      lmne_pkg::MD_BULLET: p_mask = 10'd1;
      lmne_pkg::MD_DEC:    p_mask = 10'((11'd1 << w) - 11'd1);
      lmne_pkg::MD_CJK,
      lmne_pkg::MD_TIB:    p_mask = 10'((11'd1 << ndig) - 11'd1);
      lmne_pkg::MD_LET:    p_mask = 10'((11'd1 << data_i.let_n) - 11'd1);
      lmne_pkg::MD_GEO: begin
        for (int i = 0; i < 5; i++) begin
          p_mask[i] = (data_i.mag_bcd[4*i +: 4] != 4'd0);
        end
      end
      lmne_pkg::MD_ARM: begin
        for (int i = 0; i < 8; i++) begin
          p_mask[i]  = (data_i.mag_bcd[4*i +: 4] != 4'd0);
          p_lenm1[i] = (i >= 4) ? 2'd1 : 2'd0;
        end
      end
      lmne_pkg::MD_ROMAN: begin
        for (int i = 0; i < 4; i++) begin
          x = data_i.mag_bcd[4*i +: 4];
          p_mask[i] = (x != 4'd0);
          case (x)
            4'd2, 4'd4, 4'd6, 4'd9: p_lenm1[i] = 2'd1;
            4'd3, 4'd7:             p_lenm1[i] = 2'd2;
            4'd8:                   p_lenm1[i] = 2'd3;
            default:                p_lenm1[i] = 2'd0;
          endcase
        end
      end
      default: p_mask = 10'd0;
    endcase
    p_suflen = 2'd0;
    if (data_i.suffix) begin
      case (data_i.kind) inside
        lmne_pkg::KIND_DECIMAL, lmne_pkg::KIND_ZERO_PAD: p_suflen = 2'd2;
        [lmne_pkg::KIND_LOWER_ROMAN:lmne_pkg::KIND_UPPER_LATIN]: p_suflen = 2'd2;
        lmne_pkg::KIND_CJK: p_suflen = 2'd1;
        default: p_suflen = 2'd0;
      endcase
    end
    p_top = lmne_pkg::hi_bit(p_mask);
  end

  assign load   = valid_i && !busy_q;
  assign take_o = load;
  assign adv    = busy_q && (!out_valid_q || m_axis_tready);
  assign nxt    = lmne_pkg::hi_bit(mask_q & 10'((11'd1 << pos_q) - 11'd1));
  assign end_pos = (sub_q == lenm1_q[pos_q]);

  always_comb begin
    logic [3:0]  x;
    logic [4:0]  r;
    logic [3:0]  bi;
    logic        up;
    logic [20:0] off;
    x   = dig_q[pos_q];
    r   = let_q[pos_q[2:0]];
    bi  = {1'b0, pos_q[1:0], 1'b0};
    up  = (kind_q == lmne_pkg::KIND_UPPER_ROMAN) || (kind_q == lmne_pkg::KIND_UPPER_ARMENIAN);
    off = up ? 21'h0 : 21'h30;
    cp   = 21'h0;
    last = 1'b0;
    case (ph_q)
      lmne_pkg::PH_SIGN: cp = 21'h2D;
      lmne_pkg::PH_BODY: begin
        last = end_pos && !nxt[4] && (suflen_q == 2'd0);
        case (mode_q)
          lmne_pkg::MD_BULLET: begin
            case (kind_q)
              lmne_pkg::KIND_DISC:   cp = 21'h25CF;
              lmne_pkg::KIND_CIRCLE: cp = 21'h25CB;
              default:               cp = 21'h25A1;
            endcase
          end
          lmne_pkg::MD_DEC: cp = 21'h30 + 21'(x);
          lmne_pkg::MD_CJK: cp = lmne_pkg::cjk_sym(x);
          lmne_pkg::MD_TIB: cp = 21'h0F20 + 21'(x);
          lmne_pkg::MD_GEO: cp = (pos_q == 4'd4) ? 21'h10F5 : lmne_pkg::geo_sym(pos_q[1:0], x);
          lmne_pkg::MD_ROMAN: begin
            if (x == 4'd9) begin
              cp = lmne_pkg::roman_sym(up, (sub_q == 2'd0) ? bi : bi + 4'd2);
            end else if (x == 4'd4) begin
              cp = lmne_pkg::roman_sym(up, (sub_q == 2'd0) ? bi : bi + 4'd1);
            end else if (x >= 4'd5) begin
              cp = lmne_pkg::roman_sym(up, (sub_q == 2'd0) ? bi + 4'd1 : bi);
            end else begin
              cp = lmne_pkg::roman_sym(up, bi);
            end
          end
          lmne_pkg::MD_ARM: begin
            if (sub_q != 2'd0) begin
              cp = 21'h0302;
            end else begin
              case (pos_q[1:0])
                2'd3:    cp = (x == 4'd7) ? 21'h0552 + off : 21'h054B + off + 21'(x);
                2'd2:    cp = 21'h0542 + off + 21'(x);
                2'd1:    cp = 21'h0539 + off + 21'(x);
                default: cp = 21'h0530 + off + 21'(x);
              endcase
            end
          end
          lmne_pkg::MD_LET: begin
            case (kind_q)
              lmne_pkg::KIND_LOWER_GREEK:
                cp = 21'h03B1 + 21'(r) + ((r >= 5'd17) ? 21'd1 : 21'd0);
              lmne_pkg::KIND_LOWER_LATIN: cp = 21'h61 + 21'(r);
              default:                    cp = 21'h41 + 21'(r);
            endcase
          end
          default: cp = 21'h0;
        endcase
      end
      lmne_pkg::PH_SUF: begin
        last = (suflen_q == 2'd1) || sp_q;
        case (kind_q) inside
          lmne_pkg::KIND_DECIMAL, lmne_pkg::KIND_ZERO_PAD: cp = sp_q ? 21'h20 : 21'h2E;
          lmne_pkg::KIND_CJK: cp = 21'h3001;
          default: cp = sp_q ? 21'h20 : 21'h29;
        endcase
      end
      default: cp = 21'h0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    pos_d  = pos_q;
    sub_d  = sub_q;
    sp_d   = sp_q;
    if (load) begin
      busy_d = p_sign || (p_mask != 10'd0) || (p_suflen != 2'd0);
      ph_d   = p_sign ? lmne_pkg::PH_SIGN :
               ((p_mask != 10'd0) ? lmne_pkg::PH_BODY : lmne_pkg::PH_SUF);
      pos_d  = p_top[3:0];
      sub_d  = 2'd0;
      sp_d   = 1'b0;
    end else if (adv) begin
      case (ph_q)
        lmne_pkg::PH_SIGN: ph_d = lmne_pkg::PH_BODY;
        lmne_pkg::PH_BODY: begin
          if (!end_pos) begin
            sub_d = sub_q + 2'd1;
          end else if (nxt[4]) begin
            pos_d = nxt[3:0];
            sub_d = 2'd0;
          end else if (suflen_q != 2'd0) begin
            ph_d = lmne_pkg::PH_SUF;
            sp_d = 1'b0;
          end else begin
            busy_d = 1'b0;
          end
        end
        lmne_pkg::PH_SUF: begin
          if (last) begin
            busy_d = 1'b0;
          end else begin
            sp_d = 1'b1;
          end
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ph_q        <= lmne_pkg::PH_SIGN;
      pos_q       <= 4'd0;
      sub_q       <= 2'd0;
      sp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      pos_q  <= pos_d;
      sub_q  <= sub_d;
      sp_q   <= sp_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q   <= p_mode;
      kind_q   <= data_i.kind;
      mask_q   <= p_mask;
      lenm1_q  <= p_lenm1;
      suflen_q <= p_suflen;
      dig_q    <= data_i.mag_bcd;
      let_q    <= data_i.let_dig;
    end
    if (adv) begin
      cp_q   <= cp;
      last_q <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, cp_q};
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the list marker numeral encoder top level.
`timescale 1ns / 100ps
`default_nettype none

module testbench;

  typedef struct {
    logic [20:0] cp;
    logic        lst;
  } glyph_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  glyph_t      pending_glyphs[$];
  glyph_t      marker[$];
  int          error_count = 0;
  int          markers_sent = 0;
  int          glyphs_seen = 0;
  bit          hold_sink = 1'b0;
  bit          hold_done = 1'b0;
  bit          sink_gaps = 1'b1;

  list_marker_numeral_encoder_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  task automatic put(logic [20:0] cp);
    glyph_t g;
    if (marker.size() < 17) begin
      g.cp = cp;
      g.lst = 1'b0;
      marker.push_back(g);
    end
  endtask

  task automatic put_digits(logic [31:0] v, int width, logic [3:0] kind);
    logic [3:0] dg[$];
    dg = {};
    do begin
      dg.push_front(4'(v % 10));
      v = v / 10;
    end while (v != 0);
    while (dg.size() < width) dg.push_front(4'd0);
    foreach (dg[i]) begin
      if (kind == lmne_pkg::KIND_CJK) put(lmne_pkg::cjk_sym(dg[i]));
      else if (kind == lmne_pkg::KIND_TIBETAN) put(21'h0F20 + 21'(dg[i]));
      else put(21'h30 + 21'(dg[i]));
    end
  endtask

  task automatic put_signed_decimal(longint n);
    if (n < 0) put(21'h2D);
    put_digits(32'(n < 0 ? -n : n), 1, lmne_pkg::KIND_DECIMAL);
  endtask

  task automatic put_roman(int n, bit upper);
    int x;
    int d;
    int scale;
    logic [20:0] sym[7];
    string s;
    s = upper ? "IVXLCDM" : "ivxlcdm";
    for (int i = 0; i < 7; i++) sym[i] = 21'(s[i]);
    scale = 1000;
    d = 6;
    while (d >= 0) begin
      x = (n / scale) % 10;
      if (x == 9) begin
        put(sym[d]); put(sym[d + 2]);
      end else if (x == 4) begin
        put(sym[d]); put(sym[d + 1]);
      end else begin
        if (x >= 5) put(sym[d + 1]);
        for (int i = 0; i < x % 5; i++) put(sym[d]);
      end
      scale = scale / 10;
      d = d - 2;
    end
  endtask

  task automatic put_armenian_group(int n, bit upper, bit hat);
    int off;
    int t;
    int h;
    int e;
    int o;
    off = upper ? 0 : 'h30;
    t = (n / 1000) % 10;
    h = (n / 100) % 10;
    e = (n / 10) % 10;
    o = n % 10;
    if (t != 0) begin
      put(21'(t == 7 ? 'h552 + off : 'h54C - 1 + off + t));
      if (hat) put(21'h302);
    end
    if (h != 0) begin
      put(21'('h543 - 1 + off + h));
      if (hat) put(21'h302);
    end
    if (e != 0) begin
      put(21'('h53A - 1 + off + e));
      if (hat) put(21'h302);
    end
    if (o != 0) begin
      put(21'('h531 - 1 + off + o));
      if (hat) put(21'h302);
    end
  endtask

  task automatic put_letters(logic [31:0] n, logic [3:0] kind);
    logic [31:0] radix;
    logic [31:0] r;
    logic [31:0] dg[$];
    radix = (kind == lmne_pkg::KIND_LOWER_GREEK) ? 32'd24 : 32'd26;
    dg = {};
    while (n != 0) begin
      n = n - 1;
      dg.push_front(n % radix);
      n = n / radix;
    end
    foreach (dg[i]) begin
      r = dg[i];
      if (kind == lmne_pkg::KIND_LOWER_GREEK) put(21'(32'h3B1 + r + (r >= 17 ? 32'd1 : 32'd0)));
      else if (kind == lmne_pkg::KIND_LOWER_LATIN) put(21'(32'h61 + r));
      else put(21'(32'h41 + r));
    end
  endtask

  task automatic predict_marker(logic [3:0] kind, logic [31:0] raw, logic [30:0] lim,
                                logic suf);
    longint n;
    longint v;
    int nd;
    n = longint'($signed(raw));
    marker = {};
    case (kind)
      lmne_pkg::KIND_DISC: put(21'h25CF);
      lmne_pkg::KIND_CIRCLE: put(21'h25CB);
      lmne_pkg::KIND_SQUARE: put(21'h25A1);
      lmne_pkg::KIND_DECIMAL: put_signed_decimal(n);
      lmne_pkg::KIND_ZERO_PAD: begin
        if (n <= 0 || n > longint'(lim)) begin
          put_signed_decimal(n);
        end else begin
          nd = 1;
          v = longint'(lim);
          while (v >= 10) begin
            nd++;
            v = v / 10;
          end
          put_digits(raw, nd, lmne_pkg::KIND_DECIMAL);
        end
      end
      lmne_pkg::KIND_LOWER_ROMAN, lmne_pkg::KIND_UPPER_ROMAN: begin
        if (n < 1 || n > 3999) put_signed_decimal(n);
        else put_roman(int'(n), kind == lmne_pkg::KIND_UPPER_ROMAN);
      end
      lmne_pkg::KIND_LOWER_ARMENIAN, lmne_pkg::KIND_UPPER_ARMENIAN: begin
        if (n < 0 || n > 99999999) begin
          put_signed_decimal(n);
        end else begin
          put_armenian_group(int'(n / 10000), kind == lmne_pkg::KIND_UPPER_ARMENIAN, 1'b1);
          put_armenian_group(int'(n % 10000), kind == lmne_pkg::KIND_UPPER_ARMENIAN, 1'b0);
        end
      end
      lmne_pkg::KIND_GEORGIAN: begin
        if (n < 1 || n > 19999) begin
          put_signed_decimal(n);
        end else begin
          if (n > 9999) put(21'h10F5);
          for (int p = 3; p >= 0; p--) begin
            nd = int'((n / (10 ** p)) % 10);
            if (nd != 0) put(lmne_pkg::geo_sym(2'(p), 4'(nd)));
          end
        end
      end
      lmne_pkg::KIND_LOWER_GREEK, lmne_pkg::KIND_LOWER_LATIN,
      lmne_pkg::KIND_UPPER_LATIN: begin
        if (n <= 0) put_signed_decimal(n);
        else put_letters(raw, kind);
      end
      lmne_pkg::KIND_CJK, lmne_pkg::KIND_TIBETAN: begin
        if (n < 0) put_signed_decimal(n);
        else put_digits(raw, 1, kind);
      end
      default: ;
    endcase
    if (suf) begin
      if (kind == lmne_pkg::KIND_DECIMAL || kind == lmne_pkg::KIND_ZERO_PAD) begin
        put(21'h2E); put(21'h20);
      end else if (kind >= lmne_pkg::KIND_LOWER_ROMAN && kind <= lmne_pkg::KIND_UPPER_LATIN) begin
        put(21'h29); put(21'h20);
      end else if (kind == lmne_pkg::KIND_CJK) begin
        put(21'h3001);
      end
    end
    if (marker.size() > 0) marker[marker.size() - 1].lst = 1'b1;
    foreach (marker[i]) pending_glyphs.push_back(marker[i]);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic send_marker(logic [3:0] kind, logic [31:0] raw, logic [30:0] lim,
                             logic suf, bit gaps);
    int idle;
    if (gaps && $urandom_range(0, 2) == 0) begin
      idle = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    predict_marker(kind, raw, lim, suf);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {suf, lim, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    markers_sent++;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_glyphs.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_number();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 30);
      1: return $urandom_range(1, 4000);
      2: return $urandom_range(1, 20000);
      3: return $urandom_range(0, 100000000);
      4: return -$urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edges[8];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1, 3888, 19999, 99999999};
    for (int k = 0; k < 16; k++) send_marker(4'(k), edges[k % 8], 31'h7FFF_FFFF, k[0], 1'b0);
    send_marker(lmne_pkg::KIND_ZERO_PAD, 7, 31'd1000, 1'b1, 1'b0);
    send_marker(lmne_pkg::KIND_ZERO_PAD, 1001, 31'd1000, 1'b0, 1'b0);
    send_marker(lmne_pkg::KIND_ZERO_PAD, 5, 31'd0, 1'b1, 1'b0);
    send_marker(lmne_pkg::KIND_LOWER_ROMAN, 4000, 31'd0, 1'b1, 1'b0);
    send_marker(lmne_pkg::KIND_GEORGIAN, 20000, 31'd0, 1'b1, 1'b0);
    send_marker(lmne_pkg::KIND_UPPER_ARMENIAN, 77777777, 31'd0, 1'b1, 1'b0);
    send_marker(lmne_pkg::KIND_UPPER_ARMENIAN, 100000000, 31'd0, 1'b0, 1'b0);
    send_marker(lmne_pkg::KIND_LOWER_GREEK, 24 * 25 + 18, 31'd0, 1'b1, 1'b0);
    send_marker(lmne_pkg::KIND_UPPER_LATIN, 702, 31'd0, 1'b1, 1'b0);
    stop_sending();
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [3:0] kind;
    for (int i = 0; i < count; i++) begin
      kind = 4'($urandom_range(0, 15));
      send_marker(kind, random_number(),
                  ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 99999)),
                  1'($urandom), 1'b1);
    end
    stop_sending();
    wait_drained();
  endtask

  task automatic test_back_pressure();
    hold_sink = 1'b1;
    sink_gaps = 1'b0;
    for (int i = 0; i < 30; i++) begin
      send_marker(lmne_pkg::KIND_DECIMAL, $urandom, 31'd0, 1'b1, 1'b0);
    end
    stop_sending();
    hold_sink = 1'b0;
    sink_gaps = 1'b1;
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    int hold_cycles;
    if (hold_sink && !hold_done) begin
      hold_cycles = 0;
      m_axis_tready <= 1'b0;
      while (hold_cycles < 300) begin
        @(posedge clk_i);
        hold_cycles++;
      end
      hold_done = 1'b1;
    end
    if (!sink_gaps) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 3) != 0) m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    glyph_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      glyphs_seen++;
      if (pending_glyphs.size() == 0) begin
        report_mismatch("unexpected code point", 32'(m_axis_tdata), 0);
      end else begin
        want = pending_glyphs.pop_front();
        if (m_axis_tdata[20:0] != want.cp) report_mismatch("code_point", 32'(m_axis_tdata[20:0]), 32'(want.cp));
        if (m_axis_tdata[23:21] != 3'd0) report_mismatch("tdata fill", 32'(m_axis_tdata[23:21]), 0);
        if (m_axis_tlast != want.lst) report_mismatch("last", 32'(m_axis_tlast), 32'(want.lst));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_back_pressure();
    test_random(150);
    if (pending_glyphs.size() != 0) begin
      report_mismatch("code points never sent", 32'(pending_glyphs.size()), 0);
    end
    $display("Ran %0d markers over all list styles, fallbacks and suffixes; %0d code points checked.",
             markers_sent, glyphs_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
